// ===== rtl/cdn_pkg.sv =====
// cdn_pkg: shared types and constants of the calendar date normalizer
// no dependencies; imported by cdn_month_len, the top level and the checker

package cdn_pkg;

    // fixed field widths
    localparam int DAY_IN_W   = 16;
    localparam int MONTH_IN_W = 12;
    localparam int YEAR_W     = 14;
    localparam int DAY_OUT_W  = 5;
    localparam int MONTH_W    = 4;
    localparam int YMOD_W     = 9;

    // default width of the day counter
    localparam int DAY_BITS_DEF = 16;

    // calendar constants
    localparam int MONTHS_PER_YEAR = 12;
    localparam int CENTURY_YEARS   = 100;
    localparam int CYCLE_YEARS     = 400;
    localparam int DAYS_FEB        = 28;
    localparam int DAYS_FEB_LEAP   = 29;
    localparam int DAYS_SHORT      = 30;
    localparam int DAYS_LONG       = 31;

    // month codes
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_APR = 4'd4;
    localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] M_NOV = 4'd11;

    // input beat
    typedef struct packed {
        logic [DAY_IN_W-1:0]   day_in;
        logic [MONTH_IN_W-1:0] month_in;
        logic [YEAR_W-1:0]     year_in;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic                 date_valid;
        logic [DAY_OUT_W-1:0] day_out;
        logic [MONTH_W-1:0]   month_out;
        logic [YEAR_W-1:0]    year_out;
    } t_out_beat;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FOLD = 5'b00010,
        S_MOD  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ===== rtl/cdn_sub_unit.sv =====
// cdn_sub_unit: shared subtract and compare unit of the date normalizer
// depends on nothing; the sequencer in the top level feeds its operands

module cdn_sub_unit #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow,
    output logic             o_gt
);

    // one subtractor, borrow out tells a < b
    assign {o_borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};

    // a strictly greater than b
    assign o_gt = !o_borrow && (|o_diff);

endmodule

// ===== rtl/cdn_month_len.sv =====
// cdn_month_len: days in a month for the current month and year position
// depends on cdn_pkg for calendar constants and month codes

module cdn_month_len (
    input  logic [cdn_pkg::MONTH_W-1:0]   i_month,
    input  logic [1:0]                    i_year_lsb,
    input  logic [cdn_pkg::YMOD_W-1:0]    i_year_mod,
    output logic [cdn_pkg::DAY_OUT_W-1:0] o_days
);
    import cdn_pkg::*;

    logic leap;

    // leap: divisible by 4, century years only when divisible by 400
    assign leap = (i_year_lsb == 2'b00)
               && (i_year_mod != YMOD_W'(CENTURY_YEARS))
               && (i_year_mod != YMOD_W'(2 * CENTURY_YEARS))
               && (i_year_mod != YMOD_W'(3 * CENTURY_YEARS));

    // month length lookup
    always_comb begin
        case (i_month)
            M_FEB:   o_days = leap ? DAY_OUT_W'(DAYS_FEB_LEAP) : DAY_OUT_W'(DAYS_FEB);
            M_APR:   o_days = DAY_OUT_W'(DAYS_SHORT);
            M_JUN:   o_days = DAY_OUT_W'(DAYS_SHORT);
            M_SEP:   o_days = DAY_OUT_W'(DAYS_SHORT);
            M_NOV:   o_days = DAY_OUT_W'(DAYS_SHORT);
            default: o_days = DAY_OUT_W'(DAYS_LONG);
        endcase
    end

endmodule

// ===== rtl/calendar_date_normalizer.sv =====
// calendar_date_normalizer: takes an input beat, folds surplus months into years, finds the
// year position in the 400-year cycle, then walks months until the day fits; a zero field
// skips straight to the done state and gives an all-zero result. one item at a time: the
// month walk (one subtract per month in the shared unit) sets how long an item takes, and
// the next beat is taken once the result sits in the output register.
// synchronous active-low reset clears sequencer and output valid.

module calendar_date_normalizer #(
    parameter int DAY_BITS = cdn_pkg::DAY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cdn_pkg::t_in_beat i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output cdn_pkg::t_out_beat o_out_data,
    input  logic              i_out_stall
);
    import cdn_pkg::*;

    localparam int W  = (DAY_BITS > YEAR_W) ? DAY_BITS : YEAR_W;
    localparam int DW = (DAY_BITS > DAY_IN_W) ? DAY_BITS : DAY_IN_W;

    t_state                r_state, n_state;
    logic [DAY_BITS-1:0]   r_d, n_d;
    logic [MONTH_IN_W-1:0] r_m, n_m;
    logic [YEAR_W-1:0]     r_y, n_y;
    logic [YEAR_W-1:0]     r_ym, n_ym;
    logic                  r_zero, n_zero;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    logic [DW-1:0]        day_ext;
    logic [DAY_BITS-1:0]  day_masked;
    logic [W-1:0]         op_a, op_b, diff;
    logic                 borrow, gt;
    logic [DAY_OUT_W-1:0] dim;

    // day count masked to the counter width
    assign day_ext    = DW'(i_in_data.day_in);
    assign day_masked = day_ext[DAY_BITS-1:0];

    // length of the current month
    cdn_month_len u_month_len (
        .i_month    (r_m[MONTH_W-1:0]),
        .i_year_lsb (r_y[1:0]),
        .i_year_mod (r_ym[YMOD_W-1:0]),
        .o_days     (dim)
    );

    // operand select for the shared unit
    always_comb begin
        case (r_state)
            S_FOLD: begin
                op_a = W'(r_m);
                op_b = W'(MONTHS_PER_YEAR);
            end
            S_MOD: begin
                op_a = W'(r_ym);
                op_b = W'(CYCLE_YEARS);
            end
            S_WALK: begin
                op_a = W'(r_d);
                op_b = W'(dim);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    cdn_sub_unit #(
        .WIDTH (W)
    ) u_sub (
        .i_a      (op_a),
        .i_b      (op_b),
        .o_diff   (diff),
        .o_borrow (borrow),
        .o_gt     (gt)
    );

    // sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_m         = r_m;
        n_y         = r_y;
        n_ym        = r_ym;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            // take a beat, keep month zero-based for the fold
            S_IDLE: begin
                if (i_in_valid) begin
                    n_d    = day_masked;
                    n_m    = i_in_data.month_in - 12'd1;
                    n_y    = i_in_data.year_in;
                    n_zero = (day_masked == '0) || (i_in_data.month_in == '0)
                          || (i_in_data.year_in == '0);
                    n_state = n_zero ? S_DONE : S_FOLD;
                end
            end
            // fold surplus months into years, twelve at a time
            S_FOLD: begin
                if (!borrow) begin
                    n_m = diff[MONTH_IN_W-1:0];
                    n_y = r_y + 14'd1;
                end else begin
                    n_m     = r_m + 12'd1;
                    n_ym    = r_y;
                    n_state = S_MOD;
                end
            end
            // year position inside the 400-year cycle
            S_MOD: begin
                if (!borrow) begin
                    n_ym = diff[YEAR_W-1:0];
                end else begin
                    n_state = S_WALK;
                end
            end
            // take one month length per cycle until the day fits
            S_WALK: begin
                if (gt) begin
                    n_d = diff[DAY_BITS-1:0];
                    if (r_m == MONTH_IN_W'(MONTHS_PER_YEAR)) begin
                        n_m  = 12'd1;
                        n_y  = r_y + 14'd1;
                        n_ym = (r_ym == YEAR_W'(CYCLE_YEARS - 1)) ? '0 : r_ym + 14'd1;
                    end else begin
                        n_m = r_m + 12'd1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_zero) begin
                        n_out = '0;
                    end else begin
                        n_out.date_valid = 1'b1;
                        n_out.day_out    = r_d[DAY_OUT_W-1:0];
                        n_out.month_out  = r_m[MONTH_W-1:0];
                        n_out.year_out   = r_y;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_m    <= n_m;
        r_y    <= n_y;
        r_ym   <= n_ym;
        r_zero <= n_zero;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/cdn_checker.sv =====
// cdn_checker: port-level assertions for the calendar date normalizer
// depends on cdn_pkg; bound to the top level at the end of this file

module cdn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input cdn_pkg::t_out_beat o_out_data,
    input logic               i_out_stall
);
    import cdn_pkg::*;

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // an invalid date is all zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.date_valid) |->
            (o_out_data.day_out == '0 && o_out_data.month_out == '0
             && o_out_data.year_out == '0))
        else $error("invalid result carries nonzero fields");

    // a valid date has a day and a month in range
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.date_valid) |->
            (o_out_data.day_out != '0 && o_out_data.month_out != '0
             && o_out_data.month_out <= MONTH_W'(MONTHS_PER_YEAR)))
        else $error("normalized date out of range");

endmodule

bind calendar_date_normalizer cdn_checker u_cdn_checker (.*);
